>>> rtl/vnorm_pkg.sv
// shared types and constants for the vector norm block
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;

  // mode register codes
  localparam logic [1:0] MODE_L2  = 2'd0;
  localparam logic [1:0] MODE_L1  = 2'd1;
  localparam logic [1:0] MODE_INF = 2'd2;

  localparam int ELEM_W    = 32;
  localparam int ACC_W     = 64;
  localparam int NORM_W    = 48;
  localparam int ROOT_W    = ACC_W / 2;
  localparam int ROOT_STEPS = ACC_W / 2;

  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};

  localparam int QUEUE_DEPTH_DEF = 4;

  // per element operation class
  typedef enum logic [1:0] {
    OP_L2,
    OP_L1,
    OP_INF
  } op_t;

  // finished vector handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             sat;
    logic             root;
  } vec_entry_t;

endpackage
`default_nettype wire

>>> rtl/vector_norm_l1_l2_linf.sv
// vector norm top level: one element per cycle while in_ready is high,
// norm out on the last element
// the back end takes no new vector while an L2 norm is in its bit-serial square root and
// handoff, and finishes one L1 or infinity norm per cycle while out_ready is high; a queue
// of finished vectors lets the front keep streaming
// reset clears the mode to L2, the accumulator and its saturation flag, the queue and out_valid
`timescale 1ns / 1ps
`default_nettype none
module vector_norm_l1_l2_linf #(
  parameter int QUEUE_DEPTH = vnorm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                norm_mode_we,
  input  wire logic [1:0]                          norm_mode_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [vnorm_pkg::ELEM_W-1:0] element,
  input  wire logic                                last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [vnorm_pkg::NORM_W-1:0]             norm_value,
  output logic                                     overflow
);
  import vnorm_pkg::*;

  logic       push;
  vec_entry_t push_data;
  logic       q_full;
  logic       pop;
  vec_entry_t pop_data;
  logic       q_valid;

  // element intake and accumulation
  vnorm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .norm_mode_we    (norm_mode_we),
    .norm_mode_wdata (norm_mode_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .element         (element),
    .last            (last),
    .push            (push),
    .push_data       (push_data),
    .q_full          (q_full)
  );

  // finished vectors waiting for readout
  vnorm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // readout and square root
  vnorm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .norm_value (norm_value),
    .overflow   (overflow)
  );

endmodule
`default_nettype wire

>>> rtl/vnorm_front.sv
// front end: element intake, squaring and saturating accumulation or running maximum
`timescale 1ns / 1ps
`default_nettype none
module vnorm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          norm_mode_we,
  input  wire logic [1:0]                    norm_mode_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [vnorm_pkg::ELEM_W-1:0] element,
  input  wire logic                          last,
  output logic                               push,
  output vnorm_pkg::vec_entry_t              push_data,
  input  wire logic                          q_full
);
  import vnorm_pkg::*;

  logic [1:0]        mode;
  logic              valid1;
  logic [ELEM_W-1:0] mag1;
  op_t               op1;
  logic              last1;
  logic              valid2;
  logic [ACC_W-1:0]  sq2;
  logic [ELEM_W-1:0] mag2;
  op_t               op2;
  logic              last2;
  logic [ACC_W-1:0]  acc;
  logic              sat;

  logic              en;
  logic [ELEM_W-1:0] mag_in;
  op_t               op_in;
  logic [ACC_W:0]    sum_l1;
  logic [ACC_W:0]    sum_l2;
  logic [ACC_W-1:0]  acc_next;
  logic              sat_next;

  // pipeline moves unless a finished vector cannot enter the queue
  assign en       = !(valid2 && last2 && q_full);
  assign in_ready = en;

  // magnitude and operation class of the incoming element
  assign mag_in = element[ELEM_W-1] ? ELEM_W'(-element) : ELEM_W'(element);
  always_comb begin
    case (mode)
      MODE_L1:  op_in = OP_L1;
      MODE_INF: op_in = OP_INF;
      default:  op_in = OP_L2;
    endcase
  end

  // saturating accumulate
  assign sum_l1 = {1'b0, acc} + {{(ACC_W+1-ELEM_W){1'b0}}, mag2};
  assign sum_l2 = {1'b0, acc} + {1'b0, sq2};
  always_comb begin
    acc_next = acc;
    sat_next = sat;
    case (op2)
      OP_L1: begin
        if ((|acc[ACC_W-1:NORM_W]) || (|sum_l1[ACC_W:NORM_W])) begin
          acc_next = {{(ACC_W-NORM_W){1'b0}}, NORM_MAX};
          sat_next = 1'b1;
        end else begin
          acc_next = sum_l1[ACC_W-1:0];
        end
      end
      OP_INF: begin
        if ({{(ACC_W-ELEM_W){1'b0}}, mag2} > acc) begin
          acc_next = {{(ACC_W-ELEM_W){1'b0}}, mag2};
        end
      end
      default: begin
        if (sum_l2[ACC_W]) begin
          acc_next = ACC_MAX;
          sat_next = 1'b1;
        end else begin
          acc_next = sum_l2[ACC_W-1:0];
        end
      end
    endcase
  end

  // finished vector to the queue
  assign push           = en && valid2 && last2;
  assign push_data.acc  = acc_next;
  assign push_data.sat  = sat_next;
  assign push_data.root = (op2 == OP_L2);

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_L2;
    end else if (norm_mode_we) begin
      mode <= norm_mode_wdata;
    end
  end

  // pipeline control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      acc    <= '0;
      sat    <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      if (valid2) begin
        if (last2) begin
          acc <= '0;
          sat <= 1'b0;
        end else begin
          acc <= acc_next;
          sat <= sat_next;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag_in;
      op1   <= op_in;
      last1 <= last;
      sq2   <= mag1 * mag1;
      mag2  <= mag1;
      op2   <= op1;
      last2 <= last1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/vnorm_queue.sv
// small queue of finished vectors between front and back
`timescale 1ns / 1ps
`default_nettype none
module vnorm_queue #(
  parameter int DEPTH = vnorm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire vnorm_pkg::vec_entry_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output vnorm_pkg::vec_entry_t      pop_data,
  output logic                       not_empty
);
  import vnorm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vec_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/vnorm_back.sv
// back end: readout clamp, bit-serial square root and output register
`timescale 1ns / 1ps
`default_nettype none
module vnorm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire vnorm_pkg::vec_entry_t         q_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vnorm_pkg::NORM_W-1:0]       norm_value,
  output logic                               overflow
);
  import vnorm_pkg::*;

  localparam int CNT_W = $clog2(ROOT_STEPS);
  localparam int REM_W = ROOT_W + 1;
  localparam int TRY_W = ROOT_W + 3;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_STEPS - 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROOT,
    B_DONE
  } bstate_t;

  bstate_t           state;
  logic [ACC_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;
  logic              sat_hold;

  logic              out_free;
  logic [TRY_W-1:0]  rem_sh;
  logic [TRY_W-1:0]  trial;
  logic              take;
  logic [NORM_W-1:0] clamped;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == B_IDLE) && q_valid && out_free;

  // one root bit per cycle
  assign rem_sh = {rem, rad[ACC_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = (rem_sh >= trial);

  // readout clamp for sum and max modes
  assign clamped = (|q_data.acc[ACC_W-1:NORM_W]) ? NORM_MAX : q_data.acc[NORM_W-1:0];

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (q_data.root) begin
              state <= B_ROOT;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        B_ROOT: begin
          if (cnt == CNT_LAST) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          rad      <= q_data.acc;
          rem      <= '0;
          root     <= '0;
          cnt      <= '0;
          sat_hold <= q_data.sat;
          if (!q_data.root) begin
            norm_value <= clamped;
            overflow   <= q_data.sat;
          end
        end
      end
      B_ROOT: begin
        rad <= {rad[ACC_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (take) begin
          rem  <= REM_W'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      B_DONE: begin
        if (out_free) begin
          norm_value <= {{(NORM_W-ROOT_W){1'b0}}, root};
          overflow   <= sat_hold;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
